// ===== hw/rtl/pbcc_pkg.sv =====
// Shared types, constants and symbol mapping for the PBCC transmit bit chain.
// No dependencies.
package pbcc_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned WordW    = 12;
  localparam int unsigned ScrHistW = 7;
  localparam int unsigned CodHistW = 6;
  localparam int unsigned SymW     = 3;
  localparam int unsigned AmpW     = 9;
  localparam int unsigned PhaseW   = 11;
  localparam int unsigned SymPerWord = 4;
  localparam int unsigned SymCntW  = 2;
  localparam int unsigned QDepth   = 2;
  localparam int unsigned QPtrW    = 1;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 24;

  localparam logic [AmpW-1:0]   AmpLow  = 9'd196;
  localparam logic [AmpW-1:0]   AmpHigh = 9'd473;
  localparam logic [PhaseW-1:0] PhNear  = 11'd201;
  localparam logic [PhaseW-1:0] PhFar   = 11'd603;

  typedef logic [WordW-1:0] word_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic [SymW-1:0]   index;
    logic [AmpW-1:0]   amp;
    logic [PhaseW-1:0] phase;
  } sym_t;

  // source position in the punctured stream for each output bit
  function automatic logic [3:0] perm_src(input logic [3:0] k);
    logic [3:0] r;
    case (k)
      4'd0:    r = 4'd1;
      4'd1:    r = 4'd3;
      4'd2:    r = 4'd0;
      4'd3:    r = 4'd5;
      4'd4:    r = 4'd7;
      4'd5:    r = 4'd9;
      4'd6:    r = 4'd11;
      4'd7:    r = 4'd2;
      4'd8:    r = 4'd4;
      4'd9:    r = 4'd6;
      4'd10:   r = 4'd8;
      4'd11:   r = 4'd10;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic sym_t map_sym(input logic b0, input logic b1, input logic b2);
    sym_t s;
    logic [PhaseW-1:0] mag;
    mag     = b1 ? PhNear : PhFar;
    s.index = {b0, b1, b2};
    s.amp   = b2 ? AmpHigh : AmpLow;
    s.phase = b0 ? mag : (~mag + 11'd1);
    return s;
  endfunction

endpackage

// ===== hw/rtl/pbcc_transmit_bit_chain_top.sv =====
// Top level of the PBCC rate-2/3 transmit bit chain with 8-point mapping.
// Depends on pbcc_pkg, pbcc_front, pbcc_fifo, pbcc_back.
//
//   channel   dir  beat                      tdata / tuser / tlast
//   s_axis    in   one data byte             data_byte / frame_start / -
//   m_axis    out  one mapped symbol         index,amp,phase / - / last_symbol
//
// A byte is coded in the cycle it is accepted and queued (two words deep).
// Symbols leave one per cycle while the queue holds a word and m_axis is ready,
// four symbols per byte; the output register's single beat per cycle sets that rate.
// Reset clears the scrambler and coder histories, the queue and the output valid.
// Input stalls only when the queue is full; output stalls back up into it.
module pbcc_transmit_bit_chain_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tuser_i,   // [0] frame_start
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [2:0] symbol_index, [11:3] amplitude,
                                        // [22:12] phase, [23] zero
  output logic        m_axis_tlast_o    // last_symbol
);

  logic              accept, pop;
  pbcc_pkg::word_t   wword, rword;
  pbcc_pkg::q_stat_t qstat;

  assign s_axis_tready_o = !qstat.full;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  pbcc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .data_byte_i   (s_axis_tdata_i),
    .frame_start_i (s_axis_tuser_i),
    .word_o        (wword)
  );

  pbcc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .wdata_i (wword),
    .pop_i   (pop),
    .rdata_o (rword),
    .stat_o  (qstat)
  );

  pbcc_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .word_i   (rword),
    .stat_i   (qstat),
    .pop_o    (pop),
    .tvalid_o (m_axis_tvalid_o),
    .tready_i (m_axis_tready_i),
    .tdata_o  (m_axis_tdata_o),
    .tlast_o  (m_axis_tlast_o)
  );

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !qstat.empty) else $error("pop from empty queue");

  a_amp_matches_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ((m_axis_tdata_o[11:3] == pbcc_pkg::AmpHigh) == m_axis_tdata_o[0]))
    else $error("amplitude does not match symbol index");

  a_phase_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[22] != m_axis_tdata_o[2]))
    else $error("phase sign does not match symbol index");

  a_pop_sets_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> m_axis_tvalid_o && m_axis_tlast_o) else $error("word end without last beat");

endmodule

// ===== hw/rtl/pbcc_front.sv =====
// Front end: scrambles, codes, punctures and reorders one byte into a 12-bit word.
// Depends on pbcc_pkg.
module pbcc_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic [pbcc_pkg::ByteW-1:0]  data_byte_i,
  input  logic                        frame_start_i,
  output pbcc_pkg::word_t             word_o
);

  logic [pbcc_pkg::ScrHistW-1:0] scr_q, scr_d;
  logic [pbcc_pkg::CodHistW-1:0] cod_q, cod_d;
  logic [pbcc_pkg::WordW-1:0]    punct;

  always_comb begin
    logic [pbcc_pkg::ScrHistW-1:0] h;
    logic [pbcc_pkg::CodHistW-1:0] c;
    logic s, y0, y1;
    int   n;
    h = frame_start_i ? '0 : scr_q;
    c = frame_start_i ? '0 : cod_q;
    punct = '0;
    n = 0;
    for (int i = 0; i < pbcc_pkg::ByteW; i++) begin
      s  = data_byte_i[i] ^ h[3] ^ h[6];
      y0 = s ^ c[0] ^ c[2] ^ c[3] ^ c[5];
      y1 = s ^ c[1] ^ c[2] ^ c[3] ^ c[5];
      h  = {h[pbcc_pkg::ScrHistW-2:0], s};
      c  = {c[pbcc_pkg::CodHistW-2:0], s};
      punct[n] = y0;
      n = n + 1;
      if ((i % 2) == 0) begin
        punct[n] = y1;
        n = n + 1;
      end
    end
    scr_d = h;
    cod_d = c;
  end

  always_comb begin
    for (int k = 0; k < pbcc_pkg::WordW; k++) begin
      word_o[k] = punct[pbcc_pkg::perm_src(4'(k))];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_q <= '0;
      cod_q <= '0;
    end else if (accept_i) begin
      scr_q <= scr_d;
      cod_q <= cod_d;
    end
  end

endmodule

// ===== hw/rtl/pbcc_fifo.sv =====
// Short queue of coded words between front and back end.
// Depends on pbcc_pkg.
module pbcc_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  pbcc_pkg::word_t       wdata_i,
  input  logic                  pop_i,
  output pbcc_pkg::word_t       rdata_o,
  output pbcc_pkg::q_stat_t     stat_o
);

  pbcc_pkg::word_t             mem_q [pbcc_pkg::QDepth];
  logic [pbcc_pkg::QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [pbcc_pkg::QPtrW:0]    cnt_q;

  assign stat_o.full  = (cnt_q == (pbcc_pkg::QPtrW+1)'(pbcc_pkg::QDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign rdata_o      = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== hw/rtl/pbcc_back.sv =====
// Back end: splits each queued word into four mapped symbols, one per beat.
// Depends on pbcc_pkg.
module pbcc_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pbcc_pkg::word_t               word_i,
  input  pbcc_pkg::q_stat_t             stat_i,
  output logic                          pop_o,
  output logic                          tvalid_o,
  input  logic                          tready_i,
  output logic [pbcc_pkg::OutDataW-1:0] tdata_o,
  output logic                          tlast_o
);

  logic [pbcc_pkg::SymCntW-1:0] cnt_q;
  logic                         vld_q;
  pbcc_pkg::sym_t               sym_q, sym_d;
  logic                         last_q;
  logic                         adv, load;
  logic [pbcc_pkg::SymW-1:0]    grp;

  assign adv  = !vld_q || tready_i;
  assign load = adv && !stat_i.empty;
  assign pop_o = load && (cnt_q == pbcc_pkg::SymCntW'(pbcc_pkg::SymPerWord - 1));

  always_comb begin
    case (cnt_q)
      2'd0:    grp = word_i[2:0];
      2'd1:    grp = word_i[5:3];
      2'd2:    grp = word_i[8:6];
      2'd3:    grp = word_i[11:9];
      default: grp = '0;
    endcase
    sym_d = pbcc_pkg::map_sym(grp[0], grp[1], grp[2]);
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      sym_q  <= sym_d;
      last_q <= pop_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      cnt_q <= '0;
    end else if (adv) begin
      vld_q <= !stat_i.empty;
      if (load) cnt_q <= cnt_q + 1'b1;
    end
  end

  assign tvalid_o = vld_q;
  assign tlast_o  = last_q;
  assign tdata_o  = {1'b0, sym_q.phase, sym_q.amp, sym_q.index};

endmodule
